/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the markdown token scanner.
// Depends on nothing; each macro expects a clock named clk and a reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a property on the next clock edge.
`define ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* rtl/mdts_pkg.sv */
// Package for the markdown token scanner: scan phase and line state codes, token kinds,
// character constants and the queued token type. No dependencies.
`timescale 1ns / 1ps

package mdts_pkg;

	localparam int TOKEN_W = 32;

	// Scan phase codes.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HASH   = 3'd1;
	localparam logic [2:0] PH_TEXT   = 3'd2;
	localparam logic [2:0] PH_TICK1  = 3'd3;
	localparam logic [2:0] PH_TICK2  = 3'd4;
	localparam logic [2:0] PH_INLINE = 3'd5;
	localparam logic [2:0] PH_BLOCK  = 3'd6;

	// Line state codes.
	localparam logic [1:0] LS_START   = 2'd0;
	localparam logic [1:0] LS_BULLET  = 2'd1;
	localparam logic [1:0] LS_HEADING = 2'd2;

	typedef enum logic [1:0] {
		KIND_DEFAULT = 2'd0,
		KIND_PUNCT   = 2'd1,
		KIND_CODE    = 2'd2,
		KIND_TITLE   = 2'd3
	} kind_t;

	localparam logic [7:0] CH_TICK    = 8'h60;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	typedef struct packed {
		logic [TOKEN_W-1:0] start;
		logic [TOKEN_W-1:0] stop;
		kind_t              kind;
		logic               last;
	} token_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

/* rtl/markdown_token_scanner.sv */
// Markdown token scanner top level: byte-wise scan state and a four-entry token queue.
// Depends on mdts_pkg and assert_macros.svh.
`timescale 1ns / 1ps

// The scanner takes one input transfer per clock cycle while s_tready is
// high: a text byte or an end-of-buffer marker. The scan state is updated
// in the cycle of the transfer and the resulting tokens (none, one or two)
// are written into a four-entry token queue, from which one token per cycle
// leaves on the master side while m_tready is high; the last token caused
// by an input transfer carries tlast. Input is taken whenever the queue has
// room for two tokens, so with the master side ready the block sustains one
// byte per cycle until bytes that cause two tokens fill the queue. A token
// leaves the registered queue once the tokens written before it have left.
module markdown_token_scanner
	import mdts_pkg::*;
#(
	parameter int POSITION_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [7:0] text_byte
	input  logic [0:0]           s_tuser,  // [0] mode
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2*TOKEN_W-1:0] m_tdata,  // [31:0] token_start, [63:32] token_end
	output logic [1:0]           m_tuser,  // [1:0] token_kind
	output logic                 m_tlast   // last_of_run
);
`include "assert_macros.svh"

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int CNT_W = 3;

	logic [1:0]                line_q, line_nxt;
	logic [2:0]                phase_q, phase_nxt;
	logic [POSITION_WIDTH-1:0] start_q, start_nxt;
	logic [POSITION_WIDTH-1:0] off_q, off_nxt;
	logic [1:0]                hist_q, hist_nxt;

	token_t                    queue_q [DEPTH];
	logic [PTR_W-1:0]          wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]          cnt_q;

	logic                      in_fire, out_fire;
	logic                      mode;
	logic [7:0]                c;
	logic [POSITION_WIDTH-1:0] next_pos;
	logic                      tok_a_vld, tok_b_vld, run_idle;
	token_t                    tok_a, tok_b, push_first, push_second;
	logic [1:0]                n_push;
	kind_t                     text_kind;

	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;
	assign s_tready = (cnt_q <= CNT_W'(DEPTH - 2));
	assign mode     = s_tuser[0];
	assign c        = s_tdata;
	assign next_pos = off_q + POSITION_WIDTH'(1);
	assign text_kind = (line_q == LS_HEADING) ? KIND_TITLE : KIND_DEFAULT;

	// Scan state update. Token a closes the open token; token b is a bullet
	// raised when the byte starts afresh from the idle phase.
	always_comb begin
		line_nxt  = line_q;
		phase_nxt = phase_q;
		start_nxt = start_q;
		hist_nxt  = hist_q;
		off_nxt   = next_pos;
		tok_a_vld = 1'b0;
		tok_b_vld = 1'b0;
		run_idle  = 1'b0;
		tok_a     = '{start: TOKEN_W'(start_q), stop: TOKEN_W'(off_q), kind: KIND_CODE, last: 1'b1};
		tok_b     = '{start: TOKEN_W'(off_q), stop: TOKEN_W'(next_pos), kind: KIND_PUNCT,
			last: 1'b1};
		if (mode) begin
			unique case (phase_q)
				PH_HASH: begin
					tok_a_vld  = 1'b1;
					tok_a.kind = KIND_PUNCT;
				end
				PH_TEXT: begin
					tok_a_vld  = 1'b1;
					tok_a.kind = text_kind;
				end
				PH_TICK1, PH_TICK2, PH_INLINE, PH_BLOCK: begin
					tok_a_vld = 1'b1;
				end
				default: begin
				end
			endcase
			line_nxt  = LS_START;
			phase_nxt = PH_IDLE;
			start_nxt = '0;
			off_nxt   = '0;
			hist_nxt  = '0;
		end else begin
			unique case (phase_q)
				PH_HASH: begin
					if (c != CH_HASH) begin
						tok_a_vld  = 1'b1;
						tok_a.kind = KIND_PUNCT;
						run_idle   = 1'b1;
					end
				end
				PH_TEXT: begin
					if (c == CH_NEWLINE || c == CH_TICK) begin
						tok_a_vld  = 1'b1;
						tok_a.kind = text_kind;
						run_idle   = 1'b1;
					end
				end
				PH_TICK1: begin
					phase_nxt = (c == CH_TICK) ? PH_TICK2 : PH_INLINE;
				end
				PH_TICK2: begin
					if (c == CH_TICK) begin
						phase_nxt = PH_BLOCK;
						hist_nxt  = '0;
					end else begin
						tok_a_vld = 1'b1;
						run_idle  = 1'b1;
					end
				end
				PH_INLINE: begin
					if (c == CH_TICK) begin
						tok_a_vld  = 1'b1;
						tok_a.stop = TOKEN_W'(next_pos);
						phase_nxt  = PH_IDLE;
					end
				end
				PH_BLOCK: begin
					if (c == CH_TICK) begin
						if (hist_q >= 2'd2) begin
							tok_a_vld  = 1'b1;
							tok_a.stop = TOKEN_W'(next_pos);
							phase_nxt  = PH_IDLE;
							hist_nxt   = '0;
						end else begin
							hist_nxt = hist_q + 2'd1;
						end
					end else begin
						hist_nxt = '0;
					end
				end
				default: begin
					run_idle = 1'b1;
				end
			endcase

			// A byte that starts afresh from the idle phase.
			if (run_idle) begin
				phase_nxt = PH_IDLE;
				priority if (is_space(c)) begin
					if (c == CH_NEWLINE) begin
						line_nxt = LS_START;
					end
				end else if (line_q == LS_START &&
						(c == CH_STAR || c == CH_PLUS || c == CH_MINUS)) begin
					tok_b_vld = 1'b1;
					line_nxt  = LS_BULLET;
				end else begin
					start_nxt = off_q;
					if (line_q == LS_START && c == CH_HASH) begin
						line_nxt  = LS_HEADING;
						phase_nxt = PH_HASH;
					end else if (c == CH_TICK) begin
						phase_nxt = PH_TICK1;
					end else begin
						phase_nxt = PH_TEXT;
					end
				end
			end
		end
	end

	// Order the tokens of this transfer; only the final one carries last.
	always_comb begin
		push_first       = tok_a_vld ? tok_a : tok_b;
		push_first.last  = !(tok_a_vld && tok_b_vld);
		push_second      = tok_b;
		n_push           = in_fire ? (2'(tok_a_vld) + 2'(tok_b_vld)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q   <= LS_START;
			phase_q  <= PH_IDLE;
			start_q  <= '0;
			off_q    <= '0;
			hist_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_fire) begin
				line_q  <= line_nxt;
				phase_q <= phase_nxt;
				start_q <= start_nxt;
				off_q   <= off_nxt;
				hist_q  <= hist_nxt;
			end
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(out_fire);
		end
	end

	// Queue storage carries payload only.
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= push_first;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= push_second;
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {queue_q[rd_ptr_q].stop, queue_q[rd_ptr_q].start};
	assign m_tuser  = queue_q[rd_ptr_q].kind;
	assign m_tlast  = queue_q[rd_ptr_q].last;

	`ASSERT_CLK(a_queue_bound, cnt_q <= CNT_W'(DEPTH), "token queue overflow")
	`ASSERT_CLK(a_hist_in_block, (hist_q == 2'd0) || (phase_q == PH_BLOCK),
		"backtick history set outside block code")
	`ASSERT_NEXT(a_flush_resets, in_fire && mode,
		(phase_q == PH_IDLE) && (off_q == '0) && (line_q == LS_START),
		"end of buffer did not return the scanner to reset")
	`ASSERT_NEXT(a_pop_only, out_fire && (n_push == 2'd0), cnt_q == $past(cnt_q) - CNT_W'(1),
		"queue count wrong after a lone output transfer")

endmodule

/* sim/markdown_token_scanner_tb.sv */
// Self-checking testbench for markdown_token_scanner: directed and random byte streams
// with idling on both sides, checked against an in-bench token predictor.
// Depends on mdts_pkg and the scanner RTL.
`timescale 1ns / 1ps

module markdown_token_scanner_tb;
	import mdts_pkg::*;

	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 80;

	// Keeps its own copy of the scan state and the tokens still owed by the block.
	class token_scoreboard;
		token_t pending_tokens[$];
		int unsigned errors;
		int unsigned tokens_this_item;
		logic [1:0] line_state;
		logic [2:0] phase;
		logic [TOKEN_W-1:0] open_start;
		logic [TOKEN_W-1:0] offset;
		logic [1:0] tick_run;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			line_state = LS_START;
			phase = PH_IDLE;
			open_start = '0;
			offset = '0;
			tick_run = '0;
		endfunction

		function int unsigned pending();
			return pending_tokens.size();
		endfunction

		function kind_t text_kind();
			return (line_state == LS_HEADING) ? KIND_TITLE : KIND_DEFAULT;
		endfunction

		// Only the newest token of one transfer carries the last flag.
		function void add_token(input logic [TOKEN_W-1:0] first, input logic [TOKEN_W-1:0] past,
				input kind_t kind);
			token_t t;
			if (tokens_this_item != 0) begin
				t = pending_tokens.pop_back();
				t.last = 1'b0;
				pending_tokens.push_back(t);
			end
			t.start = first;
			t.stop = past;
			t.kind = kind;
			t.last = 1'b1;
			pending_tokens.push_back(t);
			tokens_this_item++;
		endfunction

		// A byte seen with no token open, or right after one has closed.
		function void start_fresh(input logic [7:0] c, input logic [TOKEN_W-1:0] p);
			phase = PH_IDLE;
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
				if (c == CH_NEWLINE)
					line_state = LS_START;
			end else if (line_state == LS_START && (c == CH_STAR || c == CH_PLUS || c == CH_MINUS)) begin
				add_token(p, p + 1'b1, KIND_PUNCT);
				line_state = LS_BULLET;
			end else begin
				open_start = p;
				if (line_state == LS_START && c == CH_HASH) begin
					line_state = LS_HEADING;
					phase = PH_HASH;
				end else if (c == CH_TICK) begin
					phase = PH_TICK1;
				end else begin
					phase = PH_TEXT;
				end
			end
		endfunction

		function void note_input(input logic eob, input logic [7:0] c);
			logic [TOKEN_W-1:0] p;
			logic [TOKEN_W-1:0] nxt;
			p = offset;
			nxt = offset + 1'b1;
			tokens_this_item = 0;
			if (eob) begin
				case (phase)
					PH_HASH: add_token(open_start, p, KIND_PUNCT);
					PH_TEXT: add_token(open_start, p, text_kind());
					PH_TICK1, PH_TICK2, PH_INLINE, PH_BLOCK: add_token(open_start, p, KIND_CODE);
					default: ;
				endcase
				restart();
				return;
			end
			case (phase)
				PH_HASH: if (c != CH_HASH) begin
					add_token(open_start, p, KIND_PUNCT);
					start_fresh(c, p);
				end
				PH_TEXT: if (c == CH_NEWLINE || c == CH_TICK) begin
					add_token(open_start, p, text_kind());
					start_fresh(c, p);
				end
				PH_TICK1: phase = (c == CH_TICK) ? PH_TICK2 : PH_INLINE;
				PH_TICK2: if (c == CH_TICK) begin
					phase = PH_BLOCK;
					tick_run = '0;
				end else begin
					add_token(open_start, p, KIND_CODE);
					start_fresh(c, p);
				end
				PH_INLINE: if (c == CH_TICK) begin
					add_token(open_start, nxt, KIND_CODE);
					phase = PH_IDLE;
				end
				PH_BLOCK: if (c == CH_TICK) begin
					if (tick_run >= 2'd2) begin
						add_token(open_start, nxt, KIND_CODE);
						phase = PH_IDLE;
						tick_run = '0;
					end else begin
						tick_run++;
					end
				end else begin
					tick_run = '0;
				end
				default: start_fresh(c, p);
			endcase
			offset = nxt;
		endfunction

		function void compare(input string field, input logic [TOKEN_W-1:0] want,
				input logic [TOKEN_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
				errors++;
			end
		endfunction

		function void check_token(input token_t got);
			token_t want;
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected token, expected none, got start %0d end %0d kind %0d last %0b",
					$time, got.start, got.stop, got.kind, got.last);
				errors++;
				return;
			end
			want = pending_tokens.pop_front();
			compare("token_start", want.start, got.start);
			compare("token_end", want.stop, got.stop);
			compare("token_kind", TOKEN_W'(want.kind), TOKEN_W'(got.kind));
			compare("last_of_run", TOKEN_W'(want.last), TOKEN_W'(got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [2*TOKEN_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	token_scoreboard board = new();
	int unsigned items_sent = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit hold_off_req = 1'b0;

	markdown_token_scanner dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Token side: checks every transfer, stalls at random and serves hold-off requests.
	initial begin
		int unsigned held;
		token_t got;
		held = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.start = m_tdata[TOKEN_W-1:0];
				got.stop = m_tdata[2*TOKEN_W-1:TOKEN_W];
				got.kind = kind_t'(m_tuser);
				got.last = m_tlast;
				board.check_token(got);
			end
			if (held != 0) begin
				held--;
				m_tready <= 1'b0;
				if (held == 0)
					hold_off_req = 1'b0;
			end else if (hold_off_req) begin
				held = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_item(input logic eob, input logic [7:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= eob;
		s_tdata <= c;
		do
			@(posedge clk);
		while (!s_tready);
		board.note_input(eob, c);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] c);
		send_item(1'b0, c);
	endtask

	task automatic end_buffer();
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] non_tick_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_TICK);
		return c;
	endfunction

	task automatic send_word(input int unsigned len);
		logic [7:0] c;
		repeat (len) begin
			c = 8'($urandom_range(33, 126));
			if (c == CH_TICK)
				c = CH_HASH;
			send_byte(c);
		end
	endtask

	// One piece of markdown-like text; most are well formed, some are raw noise.
	task automatic send_fragment();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			send_byte(CH_NEWLINE);
		end else if (roll < 24) begin
			send_byte(CH_NEWLINE);
			case ($urandom_range(0, 2))
				0: send_byte(CH_STAR);
				1: send_byte(CH_PLUS);
				default: send_byte(CH_MINUS);
			endcase
			send_byte(CH_SPACE);
			send_word($urandom_range(1, 6));
		end else if (roll < 34) begin
			send_byte(CH_NEWLINE);
			repeat ($urandom_range(1, 3))
				send_byte(CH_HASH);
			send_byte(CH_SPACE);
			send_word($urandom_range(1, 6));
		end else if (roll < 50) begin
			send_word($urandom_range(1, 6));
		end else if (roll < 58) begin
			repeat ($urandom_range(1, 3))
				case ($urandom_range(0, 5))
					0: send_byte(CH_SPACE);
					1: send_byte(CH_TAB);
					2: send_byte(CH_NEWLINE);
					3: send_byte(CH_VT);
					4: send_byte(CH_FF);
					default: send_byte(CH_CR);
				endcase
		end else if (roll < 68) begin
			send_byte(CH_TICK);
			repeat ($urandom_range(0, 5))
				send_byte(non_tick_byte());
			send_byte(CH_TICK);
		end else if (roll < 74) begin
			send_byte(CH_TICK);
			send_byte(CH_TICK);
			send_byte(non_tick_byte());
		end else if (roll < 84) begin
			repeat (3)
				send_byte(CH_TICK);
			repeat ($urandom_range(1, 8))
				send_byte(($urandom_range(0, 3) == 0) ? CH_TICK : non_tick_byte());
			repeat (3)
				send_byte(CH_TICK);
		end else if (roll < 96) begin
			repeat ($urandom_range(1, 3))
				send_byte(8'($urandom_range(0, 255)));
		end else begin
			end_buffer();
		end
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned target;
		target = items_sent + count;
		while (items_sent < target)
			send_fragment();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bullets of each kind, the first followed by text ended by a newline.
		send_byte(CH_STAR);
		send_byte(8'h41);
		send_byte(CH_NEWLINE);
		send_byte(CH_PLUS);
		send_byte(CH_NEWLINE);
		send_byte(CH_MINUS);
		send_byte(CH_NEWLINE);
		// A two-byte code span followed by a bullet gives two tokens in one transfer.
		send_byte(CH_TICK);
		send_byte(CH_TICK);
		send_byte(CH_MINUS);
		send_byte(CH_TICK);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(CH_TICK);
		repeat (3)
			send_byte(CH_TICK);
		send_byte(CH_TICK);
		send_byte(8'h61);
		repeat (3)
			send_byte(CH_TICK);
		// End of buffer flushes whatever token is open.
		send_byte(CH_HASH);
		send_byte(CH_HASH);
		send_byte(8'h54);
		end_buffer();
		send_byte(CH_TICK);
		end_buffer();
		send_byte(CH_TICK);
		send_byte(CH_TICK);
		end_buffer();
		send_byte(CH_TICK);
		send_byte(8'h61);
		end_buffer();
		repeat (3)
			send_byte(CH_TICK);
		end_buffer();
		end_buffer();
		wait_drain();

		// Full rate, with a long hold-off on the token side while bytes keep coming.
		run_random(150);
		hold_off_req = 1'b1;
		run_random(260);
		wait_drain();

		send_idle_pct = 88;
		run_random(410);
		wait_drain();

		send_idle_pct = 0;
		recv_stall_pct = 88;
		run_random(410);
		wait_drain();

		send_idle_pct = 15;
		recv_stall_pct = 15;
		hold_off_req = 1'b1;
		run_random(410);
		wait_drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
